### rtl/core/rpnae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnae_pkg
// Shared types and constants of the reverse-Polish alert equation evaluator.
// ----------------------------------------------------------------------------
package rpnae_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned REG_COUNT_DEF   = 10;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // token codes
  typedef enum logic [3:0] {
    OP_PUSH   = 4'd0,
    OP_ADD    = 4'd1,
    OP_SUB    = 4'd2,
    OP_MUL    = 4'd3,
    OP_DIV    = 4'd4,
    OP_GT     = 4'd5,
    OP_LT     = 4'd6,
    OP_EQ     = 4'd7,
    OP_DUP    = 4'd8,
    OP_STORE  = 4'd9,
    OP_RECALL = 4'd10,
    OP_END    = 4'd11
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNDERFLOW  = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_DIV_ZERO   = 3'd3,
    ST_BAD_REG    = 3'd4,
    ST_UNBALANCED = 3'd5,
    ST_BAD_OP     = 3'd6
  } status_e;

  // configuration register indexes
  typedef enum logic {
    CFG_TEST_MODE  = 1'b0,
    CFG_LEVEL_MODE = 1'b1
  } cfg_idx_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic plan;
    logic mul;
    logic div_load;
    logic div_step;
    logic fix;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_mul;
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/core/rpnae_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnae_ctrl
// Token sequencer: capture, decode, optional multiply or divide, commit.
// ----------------------------------------------------------------------------
module rpnae_ctrl import rpnae_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_DIVI  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.plan = 1'b1;
        if (stat_i.need_mul) state_d = S_MUL;
        else if (stat_i.need_div) state_d = S_DIVI;
        else state_d = S_DONE;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_FIX;
      end
      S_DIVI: begin
        cmd_o.div_load = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commit never overwrites a result still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> stat_i.out_free)
    else $error("commit while output busy");

  // an accepted token always goes through decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_DEC)
    else $error("capture not followed by decode");

  // a divider load is always followed by a divide step; the divider runs only between load and fix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_load |=> cmd_o.div_step)
    else $error("divider load not followed by step");

endmodule

### rtl/core/rpnae_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpnae_datapath
// Operand stack memory, saved registers, fixed-point units, output register.
// ----------------------------------------------------------------------------
module rpnae_datapath import rpnae_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned REG_COUNT   = REG_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  input  logic [3:0]  op_i,
  input  logic [31:0] operand_value_i,
  input  logic [3:0]  reg_index_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        equation_done_o,
  output logic        alarm_o,
  output logic [2:0]  status_o,
  output logic [7:0]  level_value_o,
  output logic        halted_o,
  input  ctl_cmd_t    cmd_i,
  output dp_stat_t    stat_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // configuration
  logic test_mode_q, level_mode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_mode_q  <= 1'b0;
      level_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEST_MODE:  test_mode_q  <= cfg_data_i;
        CFG_LEVEL_MODE: level_mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured token
  logic [3:0]  op_q;
  logic [31:0] val_q;
  logic [3:0]  ri_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      val_q <= operand_value_i;
      ri_q  <= reg_index_i;
    end
  end

  // control state
  logic [CW-1:0] count_q;
  logic          failed_q, halted_q;

  // operand stack memory, two registered read ports
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [AW-1:0] addr_top, addr_sec;
  logic signed [31:0] top_q, sec_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign addr_top = AW'(count_q - CW'(1));
  assign addr_sec = AW'(count_q - CW'(2));

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
    top_q <= stack_mem[addr_top];
    sec_q <= stack_mem[addr_sec];
  end

  // saved registers
  logic [31:0] regs_q [REG_COUNT];
  logic        ri_ok;
  assign ri_ok = ({28'd0, ri_q} < 32'(REG_COUNT));

  // decode
  logic          d_done, d_alarm, d_halt, d_fail, d_wr, d_regwr, d_mul, d_div;
  status_e       d_st;
  logic [7:0]    d_lvl;
  logic [AW-1:0] d_waddr;
  logic [CW-1:0] d_cnt;
  logic [31:0]   d_res;
  logic [32:0]   sum_add, sum_sub;
  logic [31:0]   sat_add, sat_sub, top_mag;
  logic          full, empty;

  assign full  = (count_q >= CW'(STACK_DEPTH));
  assign empty = (count_q == '0);
  assign sum_add = {top_q[31], top_q} + {sec_q[31], sec_q};
  assign sum_sub = {sec_q[31], sec_q} - {top_q[31], top_q};
  assign sat_add = (sum_add[32] != sum_add[31]) ? (sum_add[32] ? Q_MIN : Q_MAX)
                                                 : sum_add[31:0];
  assign sat_sub = (sum_sub[32] != sum_sub[31]) ? (sum_sub[32] ? Q_MIN : Q_MAX)
                                                 : sum_sub[31:0];
  assign top_mag = top_q[31] ? (32'd0 - top_q) : top_q;

  always_comb begin
    d_done  = 1'b0;
    d_alarm = 1'b0;
    d_st    = ST_OK;
    d_lvl   = 8'd0;
    d_halt  = halted_q;
    d_fail  = failed_q;
    d_wr    = 1'b0;
    d_waddr = addr_sec;
    d_cnt   = count_q;
    d_regwr = 1'b0;
    d_res   = '0;
    d_mul   = 1'b0;
    d_div   = 1'b0;
    if (halted_q) begin
      d_halt = 1'b1;
    end else if (op_q == OP_END) begin
      d_done = 1'b1;
      d_cnt  = '0;
      d_fail = 1'b0;
      if (failed_q) begin
        d_lvl = 8'hFF;
      end else if (count_q != CW'(1)) begin
        d_st  = ST_UNBALANCED;
        d_lvl = 8'hFF;
      end else if (top_q != '0 && !test_mode_q && !level_mode_q) begin
        d_alarm = 1'b1;
      end else if (level_mode_q) begin
        d_lvl  = top_q[31] ? (8'd0 - top_mag[23:16]) : top_q[23:16];
        d_halt = 1'b1;
      end
    end else if (!failed_q) begin
      case (op_q)
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_EQ: begin
          if (count_q < CW'(2)) begin
            d_st = ST_UNDERFLOW;
          end else begin
            d_wr  = 1'b1;
            d_cnt = count_q - CW'(1);
            case (op_q)
              OP_ADD: d_res = sat_add;
              OP_SUB: d_res = sat_sub;
              OP_MUL: d_mul = 1'b1;
              OP_DIV: begin
                if (top_q == '0) begin
                  if (test_mode_q) begin
                    d_res = sec_q;
                  end else begin
                    d_st  = ST_DIV_ZERO;
                    d_wr  = 1'b0;
                    d_cnt = count_q;
                  end
                end else begin
                  d_div = 1'b1;
                end
              end
              OP_GT:   d_res = (sec_q > top_q) ? Q_ONE : '0;
              OP_LT:   d_res = (sec_q < top_q) ? Q_ONE : '0;
              default: d_res = (sec_q == top_q) ? Q_ONE : '0;
            endcase
          end
        end
        OP_PUSH: begin
          if (full) begin
            d_st = ST_OVERFLOW;
          end else begin
            d_wr = 1'b1; d_waddr = AW'(count_q); d_res = val_q;
            d_cnt = count_q + CW'(1);
          end
        end
        OP_DUP: begin
          if (empty) begin
            d_st = ST_UNDERFLOW;
          end else if (full) begin
            d_st = ST_OVERFLOW;
          end else begin
            d_wr = 1'b1; d_waddr = AW'(count_q); d_res = top_q;
            d_cnt = count_q + CW'(1);
          end
        end
        OP_STORE: begin
          if (empty) begin
            d_st = ST_UNDERFLOW;
          end else if (!ri_ok) begin
            d_st = ST_BAD_REG;
          end else begin
            d_regwr = 1'b1; d_res = top_q;
            d_cnt = count_q - CW'(1);
          end
        end
        OP_RECALL: begin
          if (full) begin
            d_st = ST_OVERFLOW;
          end else if (!ri_ok) begin
            d_st = ST_BAD_REG;
          end else begin
            d_wr = 1'b1; d_waddr = AW'(count_q); d_res = regs_q[ri_q[RW-1:0]];
            d_cnt = count_q + CW'(1);
          end
        end
        default: d_st = ST_BAD_OP;
      endcase
      if (d_st != ST_OK) d_fail = 1'b1;
    end
  end

  // latched plan
  logic          p_done_q, p_alarm_q, p_halt_q, p_fail_q, p_wr_q, p_regwr_q;
  status_e       p_st_q;
  logic [7:0]    p_lvl_q;
  logic [AW-1:0] p_waddr_q;
  logic [CW-1:0] p_cnt_q;
  logic [31:0]   res_q;

  // multiplier and divider
  logic signed [63:0] prod_q;
  logic signed [47:0] prod_sh;
  logic [31:0]        mul_sat, div_sat;
  logic [47:0]        num_q;
  logic [31:0]        den_q;
  logic [32:0]        rem_q, rem_sh;
  logic               neg_q, rem_ge;
  logic [5:0]         step_q;

  assign prod_sh = prod_q[63:16];
  assign mul_sat = (prod_sh[47:31] == '0 || prod_sh[47:31] == '1) ? prod_sh[31:0]
                 : (prod_sh[47] ? Q_MIN : Q_MAX);
  assign rem_sh  = {rem_q[31:0], num_q[47]};
  assign rem_ge  = (rem_sh >= {1'b0, den_q});
  assign div_sat = neg_q ? ((num_q > 48'h0000_8000_0000) ? Q_MIN : (32'd0 - num_q[31:0]))
                         : ((num_q > 48'h0000_7FFF_FFFF) ? Q_MAX : num_q[31:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      p_done_q  <= d_done;
      p_alarm_q <= d_alarm;
      p_halt_q  <= d_halt;
      p_fail_q  <= d_fail;
      p_wr_q    <= d_wr;
      p_regwr_q <= d_regwr;
      p_st_q    <= d_st;
      p_lvl_q   <= d_lvl;
      p_waddr_q <= d_waddr;
      p_cnt_q   <= d_cnt;
      res_q     <= d_res;
    end else if (cmd_i.fix) begin
      res_q <= (op_q == OP_MUL) ? mul_sat : div_sat;
    end
    if (cmd_i.mul) prod_q <= sec_q * top_q;
    if (cmd_i.div_load) begin
      num_q  <= {(sec_q[31] ? (32'd0 - sec_q) : sec_q), 16'd0};
      den_q  <= top_mag;
      rem_q  <= '0;
      neg_q  <= sec_q[31] ^ top_q[31];
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      num_q  <= {num_q[46:0], rem_ge};
      step_q <= step_q + 6'd1;
    end
  end

  // commit to stack, registers and flags
  assign mem_we    = cmd_i.commit && p_wr_q;
  assign mem_waddr = p_waddr_q;
  assign mem_wdata = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      failed_q <= 1'b0;
      halted_q <= 1'b0;
      for (int i = 0; i < int'(REG_COUNT); i++) regs_q[i] <= '0;
    end else if (cmd_i.commit) begin
      count_q  <= p_cnt_q;
      failed_q <= p_fail_q;
      halted_q <= p_halt_q;
      if (p_regwr_q) regs_q[ri_q[RW-1:0]] <= res_q;
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      equation_done_o <= p_done_q;
      alarm_o         <= p_alarm_q;
      status_o        <= p_st_q;
      level_value_o   <= p_lvl_q;
      halted_o        <= p_halt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.need_mul = d_mul;
  assign stat_o.need_div = d_div;
  assign stat_o.div_last = (step_q == 6'd47);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // stack count stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count out of range");

  // halt is sticky until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt cleared without reset");

  // stack count moves only on commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(count_q))
    else $error("stack count changed outside commit");

endmodule

### rtl/core/rpn_alert_equation_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_alert_equation_evaluator
// Reverse-Polish evaluator of alert equations in Q16.16 saturating fixed point.
// ----------------------------------------------------------------------------
// Usage:
// - tokens enter on the in_valid_i / in_ready_o channel (op, value, register
//   index); one result transaction leaves per token on out_valid_o /
//   out_ready_i
// - the block works on one token at a time; in_ready_o is high in the idle
//   state, also while an earlier result still waits in the output register
// - after the accepting edge a token is decoded and its plan registered, then
//   committed to out_valid_o; mul adds one 32x32 multiplier stage and a
//   saturation stage before the commit; div loads the restoring divider that
//   makes one of the 48 quotient bits per cycle, then saturates the quotient
// - the next token is accepted in the cycle after the commit; no token is
//   taken while an earlier one is still in work
// - a receiver stall holds the result in the output register; the next
//   token is decoded and computed, then waits to commit until it drains
// - configuration (test mode, level mode) is written through cfg_we_i; the user
//   must write it only while the block is idle, and the block has no check on it
// - reset empties the stack, zeroes the saved registers and clears the abort
//   and halt flags; no clearing pass is needed
// ----------------------------------------------------------------------------
module rpn_alert_equation_evaluator import rpnae_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned REG_COUNT   = REG_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  op_i,
  input  logic [31:0] operand_value_i,
  input  logic [3:0]  reg_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        equation_done_o,
  output logic        alarm_o,
  output logic [2:0]  status_o,
  output logic [7:0]  level_value_o,
  output logic        halted_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  rpnae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stack, registers and arithmetic
  rpnae_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .REG_COUNT   (REG_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .operand_value_i (operand_value_i),
    .reg_index_i     (reg_index_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .equation_done_o (equation_done_o),
    .alarm_o         (alarm_o),
    .status_o        (status_o),
    .level_value_o   (level_value_o),
    .halted_o        (halted_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

### tb/tb_rpn_alert_equation_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_alert_equation_evaluator
// Self-checking testbench of the reverse-Polish alert equation evaluator.
// A queue of tokens (directed cases, then random equations with noise) feeds
// a valid/ready driver; a shadow evaluator predicts each result transaction
// and a monitor compares it field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module tb_rpn_alert_equation_evaluator;
  import rpnae_pkg::*;

  localparam int unsigned STK_DEPTH  = 16;
  localparam int unsigned NUM_REGS   = 10;
  localparam logic [3:0]  OP_BAD_LO  = 4'd12;
  localparam logic [3:0]  OP_BAD_HI  = 4'd15;
  localparam longint      CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] val;
    logic [3:0]  ri;
  } token_t;

  typedef struct {
    logic       done;
    logic       alarm;
    logic [2:0] status;
    logic [7:0] level;
    logic       halted;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i, cfg_index_i, cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [3:0]  op_i, reg_index_i;
  logic [31:0] operand_value_i;
  logic        out_valid_o, out_ready_i;
  logic        equation_done_o, alarm_o, halted_o;
  logic [2:0]  status_o;
  logic [7:0]  level_value_o;

  rpn_alert_equation_evaluator dut (.*);

  always #5 clk_i = ~clk_i;

  token_t   token_q[$];
  verdict_t verdict_q[$];
  int       send_idle_pct, recv_stall_pct;
  int       errors;
  longint   cycles;

  // shadow evaluator state
  logic signed [31:0] sh_stack[STK_DEPTH];
  logic signed [31:0] sh_regs[NUM_REGS];
  int unsigned        sh_depth;
  bit                 sh_failed, sh_halt, sh_test, sh_level;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  // integer part truncated toward zero, low byte
  function automatic logic [7:0] level_of(logic signed [31:0] v);
    longint w, ip;
    w = v;
    ip = (w >= 0) ? (w / 65536) : -((-w) / 65536);
    return ip[7:0];
  endfunction

  task automatic evaluate_token(logic [3:0] op, logic [31:0] val, logic [3:0] ri);
    verdict_t r;
    longint a, b, p;
    logic signed [31:0] res;
    bit pop;
    r = '{done: 1'b0, alarm: 1'b0, status: ST_OK, level: 8'd0, halted: 1'b0};
    if (sh_halt) begin
      r.halted = 1'b1;
      verdict_q.push_back(r);
      return;
    end
    if (op == OP_END) begin
      r.done = 1'b1;
      if (sh_failed) r.level = 8'hFF;
      else if (sh_depth != 1) begin
        r.status = ST_UNBALANCED;
        r.level = 8'hFF;
      end else if (sh_stack[0] != 0 && !sh_test && !sh_level) r.alarm = 1'b1;
      else if (sh_level) begin
        r.level = level_of(sh_stack[0]);
        sh_halt = 1'b1;
      end
      sh_depth = 0;
      sh_failed = 1'b0;
    end else if (!sh_failed) begin
      if (op >= OP_ADD && op <= OP_EQ) begin
        if (sh_depth < 2) r.status = ST_UNDERFLOW;
        else begin
          a = sh_stack[sh_depth-2];
          b = sh_stack[sh_depth-1];
          pop = 1'b1;
          res = '0;
          case (op)
            OP_ADD: res = clamp32(a + b);
            OP_SUB: res = clamp32(a - b);
            OP_MUL: begin
              p = a * b;
              res = clamp32((p >= 0) ? p / 65536 : -((-p + 65535) / 65536));
            end
            OP_DIV: begin
              if (b == 0) begin
                if (sh_test) res = a[31:0];
                else begin
                  r.status = ST_DIV_ZERO;
                  pop = 1'b0;
                end
              end else res = clamp32((a * 65536) / b);
            end
            OP_GT:   res = (a > b) ? Q_ONE : '0;
            OP_LT:   res = (a < b) ? Q_ONE : '0;
            default: res = (a == b) ? Q_ONE : '0;
          endcase
          if (pop) begin
            sh_stack[sh_depth-2] = res;
            sh_depth--;
          end
        end
      end else if (op == OP_PUSH) begin
        if (sh_depth >= STK_DEPTH) r.status = ST_OVERFLOW;
        else sh_stack[sh_depth++] = val;
      end else if (op == OP_DUP) begin
        if (sh_depth == 0) r.status = ST_UNDERFLOW;
        else if (sh_depth >= STK_DEPTH) r.status = ST_OVERFLOW;
        else begin
          sh_stack[sh_depth] = sh_stack[sh_depth-1];
          sh_depth++;
        end
      end else if (op == OP_STORE) begin
        if (sh_depth == 0) r.status = ST_UNDERFLOW;
        else if (ri >= NUM_REGS) r.status = ST_BAD_REG;
        else begin
          sh_regs[ri] = sh_stack[sh_depth-1];
          sh_depth--;
        end
      end else if (op == OP_RECALL) begin
        if (sh_depth >= STK_DEPTH) r.status = ST_OVERFLOW;
        else if (ri >= NUM_REGS) r.status = ST_BAD_REG;
        else sh_stack[sh_depth++] = sh_regs[ri];
      end else r.status = ST_BAD_OP;
      if (r.status != ST_OK) sh_failed = 1'b1;
    end
    r.halted = sh_halt;
    verdict_q.push_back(r);
  endtask

  // token driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) evaluate_token(op_i, operand_value_i, reg_index_i);
      if (!in_valid_i || in_ready_o) begin
        if (token_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i      <= 1'b1;
          op_i            <= token_q[0].op;
          operand_value_i <= token_q[0].val;
          reg_index_i     <= token_q[0].ri;
          void'(token_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result transaction done=%0b alarm=%0b st=%0d lvl=%0d h=%0b",
                   $time, equation_done_o, alarm_o, status_o, level_value_o, halted_o);
          errors++;
        end else begin
          verdict_t e;
          e = verdict_q.pop_front();
          if (e.done !== equation_done_o) begin
            $display("%0t: equation_done expected %0b actual %0b", $time, e.done,
                     equation_done_o);
            errors++;
          end
          if (e.alarm !== alarm_o) begin
            $display("%0t: alarm expected %0b actual %0b", $time, e.alarm, alarm_o);
            errors++;
          end
          if (e.status !== status_o) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
            errors++;
          end
          if (e.level !== level_value_o) begin
            $display("%0t: level_value expected %0d actual %0d", $time, e.level,
                     level_value_o);
            errors++;
          end
          if (e.halted !== halted_o) begin
            $display("%0t: halted expected %0b actual %0b", $time, e.halted, halted_o);
            errors++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic token_t tok(logic [3:0] op, logic [31:0] val, logic [3:0] ri);
    token_t t;
    t.op = op;
    t.val = val;
    t.ri = ri;
    return t;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return {16'($urandom_range(15)) - 16'd8, 16'h0};
      4:       return {{16{$urandom_range(1) ? 1'b1 : 1'b0}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_reg();
    return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(NUM_REGS-1));
  endfunction

  function automatic logic [3:0] pick_binop();
    return 4'($urandom_range(OP_EQ, OP_ADD));
  endfunction

  // one random equation: mostly well formed, some noise and broken endings
  task automatic queue_equation(int noise_pct);
    int depth, len;
    depth = 0;
    if ($urandom_range(29) == 0) begin
      // overflow run
      repeat (STK_DEPTH) token_q.push_back(tok(OP_PUSH, pick_value(), 4'd0));
      case ($urandom_range(2))
        0: token_q.push_back(tok(OP_PUSH, pick_value(), 4'd0));
        1: token_q.push_back(tok(OP_DUP, pick_value(), 4'd0));
        default: token_q.push_back(tok(OP_RECALL, pick_value(), pick_reg()));
      endcase
      token_q.push_back(tok(OP_END, pick_value(), pick_reg()));
      return;
    end
    len = $urandom_range(12, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        token_q.push_back(tok(4'($urandom_range(15)), $urandom, 4'($urandom_range(15))));
      end else if (depth < 2 || $urandom_range(99) < 35) begin
        if ($urandom_range(3) == 0) token_q.push_back(tok(OP_RECALL, $urandom, pick_reg()));
        else token_q.push_back(tok(OP_PUSH, pick_value(), 4'($urandom_range(15))));
        depth++;
      end else begin
        case ($urandom_range(5))
          0: begin
            token_q.push_back(tok(OP_DUP, $urandom, 4'($urandom_range(15))));
            depth++;
          end
          1: begin
            token_q.push_back(tok(OP_STORE, $urandom, pick_reg()));
            depth--;
          end
          default: begin
            token_q.push_back(tok(pick_binop(), $urandom, 4'($urandom_range(15))));
            depth--;
          end
        endcase
      end
    end
    if ($urandom_range(9) != 0)
      while (depth > 1) begin
        token_q.push_back(tok(pick_binop(), $urandom, 4'($urandom_range(15))));
        depth--;
      end
    token_q.push_back(tok(OP_END, $urandom, 4'($urandom_range(15))));
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx == CFG_TEST_MODE) sh_test = data;
    else sh_level = data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every token is accepted and every result has arrived
  task automatic drain();
    while (token_q.size() > 0 || in_valid_i || verdict_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic run_random(int n_items, int sidle, int rstall, int noise_pct);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    while (token_q.size() < n_items) queue_equation(noise_pct);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_TEST_MODE;
    cfg_data_i = 1'b0;
    in_valid_i = 1'b0;
    op_i = OP_PUSH;
    operand_value_i = '0;
    reg_index_i = '0;
    out_ready_i = 1'b0;
    errors = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (sh_stack[i]) sh_stack[i] = '0;
    foreach (sh_regs[i]) sh_regs[i] = '0;
    sh_depth = 0;
    sh_failed = 1'b0;
    sh_halt = 1'b0;
    sh_test = 1'b0;
    sh_level = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(CFG_TEST_MODE, 1'b0);
    write_cfg(CFG_LEVEL_MODE, 1'b0);

    // directed: saturation, all ops but lt and eq, every error path but overflow, aborted ends
    token_q.push_back(tok(OP_PUSH, Q_MAX, 4'd0));
    token_q.push_back(tok(OP_PUSH, Q_MAX, 4'd0));
    token_q.push_back(tok(OP_ADD, '0, 4'd0));
    token_q.push_back(tok(OP_PUSH, Q_MIN, 4'd0));
    token_q.push_back(tok(OP_SUB, '0, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_PUSH, Q_MIN, 4'd0));
    token_q.push_back(tok(OP_PUSH, '0, 4'd0));
    token_q.push_back(tok(OP_DIV, '0, 4'd0));
    token_q.push_back(tok(OP_PUSH, Q_ONE, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_STORE, '0, 4'd12));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_RECALL, '0, 4'd15));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_BAD_HI, 32'hFFFF_FFFF, 4'd15));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_DUP, '0, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_PUSH, 32'hFFFE_8000, 4'd0));
    token_q.push_back(tok(OP_DUP, '0, 4'd0));
    token_q.push_back(tok(OP_MUL, '0, 4'd0));
    token_q.push_back(tok(OP_STORE, '0, 4'd9));
    token_q.push_back(tok(OP_RECALL, '0, 4'd9));
    token_q.push_back(tok(OP_PUSH, 32'h0003_0000, 4'd0));
    token_q.push_back(tok(OP_DIV, '0, 4'd0));
    token_q.push_back(tok(OP_RECALL, '0, 4'd9));
    token_q.push_back(tok(OP_GT, '0, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_BAD_LO, '0, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    drain();

    // random phases with different idling patterns and settings
    run_random(400, 0, 0, 8);
    write_cfg(CFG_TEST_MODE, 1'b1);
    run_random(350, 83, 0, 8);
    write_cfg(CFG_TEST_MODE, 1'b0);
    run_random(350, 0, 83, 8);
    // level mode halts at the first balanced end that has not aborted; the rest checks the halt
    write_cfg(CFG_LEVEL_MODE, 1'b1);
    token_q.push_back(tok(OP_PUSH, 32'hFF7F_8000, 4'd0));
    token_q.push_back(tok(OP_PUSH, 32'h0001_0000, 4'd0));
    token_q.push_back(tok(OP_EQ, '0, 4'd0));
    token_q.push_back(tok(OP_LT, '0, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    token_q.push_back(tok(OP_PUSH, 32'hFF7F_8000, 4'd0));
    token_q.push_back(tok(OP_END, '0, 4'd0));
    run_random(150, 20, 20, 8);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### rpn_alert_equation_evaluator.f
rtl/core/rpnae_pkg.sv
rtl/core/rpnae_ctrl.sv
rtl/core/rpnae_datapath.sv
rtl/core/rpn_alert_equation_evaluator.sv
tb/tb_rpn_alert_equation_evaluator.sv
